[hdl/cpm_lbr_pkg.sv]
// Shared types, constants and codes for the LU library directory walker.
`timescale 1ns / 1ps
package cpm_lbr_pkg;
    localparam int SECTOR_BYTES_DEF = 128;
    localparam int MEMBER_LIMIT_DEF = 65535;

    localparam logic [2:0] KIND_ACTIVE  = 3'd0;
    localparam logic [2:0] KIND_DELETED = 3'd1;
    localparam logic [2:0] KIND_UNUSED  = 3'd2;
    localparam logic [2:0] KIND_BAD     = 3'd3;
    localparam logic [2:0] KIND_HEADER  = 3'd4;

    localparam logic [7:0] ST_ACTIVE  = 8'h00;
    localparam logic [7:0] ST_DELETED = 8'hFE;
    localparam logic [7:0] ST_UNUSED  = 8'hFF;

    // One completed entry handed from the front end to the back end.
    typedef struct packed {
        logic [17:0] entry_index;
        logic [7:0]  status;
        logic        name_bad;
        logic [15:0] first_sector;
        logic [15:0] sector_total;
        logic [15:0] date;
        logic [15:0] tod;
        logic [7:0]  pad;
    } entry_t;

    // Back end feedback to the front end.
    typedef struct packed {
        logic        walk_end;
        logic [15:0] dir_sectors;
    } walk_fb_t;

    typedef struct packed {
        logic [17:0] entry_index;
        logic [2:0]  entry_kind;
        logic [15:0] start_sector;
        logic [15:0] sector_count;
        logic [22:0] member_bytes;
        logic        present;
        logic        has_timestamp;
        logic [32:0] timestamp_seconds;
        logic        library_done;
        logic        library_valid;
        logic [15:0] active_count;
        logic [15:0] truncated_count;
    } result_t;
endpackage

[hdl/cpm_library_directory_walker.sv]
// Top level of the LU library directory walker.
//
// channel  dir  signals                       contents
// s_axis   in   tvalid tready tdata tuser     directory byte, new-library flag
// m_axis   out  tvalid tready tdata tuser     one result per 32-byte entry
// cfg      in   cfg_we cfg_wdata              library_bytes
//
// One byte per cycle while s_axis_tready is high; an entry's result then passes the queue and output registers.
// A one-entry queue separates front and back ends; an output register follows the back end.
// The last byte of an entry stalls only while that queue cannot advance.
// rst_n clears the walk state and library_bytes; bytes before a new library are dropped.
`timescale 1ns / 1ps
module cpm_library_directory_walker #(
    parameter int SECTOR_BYTES = cpm_lbr_pkg::SECTOR_BYTES_DEF,
    parameter int MEMBER_LIMIT = cpm_lbr_pkg::MEMBER_LIMIT_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // data_byte
    input  logic         s_axis_tuser,   // new_library
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // entry_index, entry_kind, start_sector, sector_count, member_bytes, present,
    // has_timestamp, timestamp_seconds, library_done, library_valid,
    // active_count, truncated_count; zero fill to 184 bits
    output logic [183:0] m_axis_tdata,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata
);
    logic [31:0]            lib_reg;
    cpm_lbr_pkg::walk_fb_t  fb;
    cpm_lbr_pkg::entry_t    ent;
    cpm_lbr_pkg::result_t   res;
    logic                   ent_valid, q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lib_reg <= '0;
        else if (cfg_we)
            lib_reg <= cfg_wdata;
    end

    cpm_lbr_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .data_byte(s_axis_tdata), .new_library(s_axis_tuser),
        .fb(fb), .ent_valid(ent_valid), .ent_ready(q_ready), .ent(ent)
    );

    cpm_lbr_back #(.SECTOR_BYTES(SECTOR_BYTES), .MEMBER_LIMIT(MEMBER_LIMIT)) u_back (
        .clk(clk), .rst_n(rst_n),
        .ent_valid(ent_valid), .ent(ent),
        .new_walk(s_axis_tvalid && s_axis_tready && s_axis_tuser),
        .library_bytes(lib_reg), .fb(fb),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
        .queue_ready(q_ready), .res(res)
    );

    assign m_axis_tdata = {5'd0, res.truncated_count, res.active_count,
        res.library_valid, res.library_done, res.timestamp_seconds,
        res.has_timestamp, res.present, res.member_bytes, res.sector_count,
        res.start_sector, res.entry_kind, res.entry_index};
endmodule

[hdl/cpm_lbr_front.sv]
// Front end: collects directory bytes into entries and checks the name.
`timescale 1ns / 1ps
module cpm_lbr_front
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               data_byte,
    input  logic                     new_library,
    input  cpm_lbr_pkg::walk_fb_t    fb,
    output logic                     ent_valid,
    input  logic                     ent_ready,
    output cpm_lbr_pkg::entry_t      ent
);
    logic [4:0]  pos_reg;
    logic [17:0] num_reg;
    logic        run_reg;
    logic        ended_reg, bad_reg, nonempty_reg;
    logic [7:0]  status_reg;
    logic [15:0] first_reg, total_reg, date0_reg, date1_reg, tod0_reg, tod1_reg;
    logic [7:0]  pad_reg;
    logic        take;
    logic [4:0]  pos;
    logic        run;
    logic [17:0] num;
    logic        ended, bad, nonempty;
    logic [6:0]  c;
    logic [15:0] date_sel, tod_sel;

    // An entry completion needs room in the queue; other bytes always go.
    assign in_ready = ent_ready || !(pos_reg == 5'd31 && run_reg && !new_library);
    assign take     = in_valid && in_ready;

    always_comb
    begin
        pos = new_library ? 5'd0 : pos_reg;
        num = new_library ? 18'd0 : num_reg;
        run = new_library || (run_reg && !fb.walk_end);
        ended = ended_reg;
        bad = bad_reg;
        nonempty = nonempty_reg;
        c = data_byte[6:0];
        if (pos == 5'd0)
        begin
            ended = 1'b0;
            bad = 1'b0;
            nonempty = 1'b0;
        end
        else if (pos <= 5'd11)
        begin
            if (num == 18'd0)
            begin
                if (data_byte != 8'h20)
                    bad = 1'b1;
            end
            else
            begin
                if (pos == 5'd9)
                begin
                    if (!nonempty)
                        bad = 1'b1;
                    ended = 1'b0;
                    nonempty = 1'b0;
                end
                if (c == 7'h20)
                    ended = 1'b1;
                else if (ended || c < 7'h21 || c > 7'h7E)
                    bad = 1'b1;
                else
                    nonempty = 1'b1;
            end
        end
        date_sel = (date1_reg != 16'd0) ? date1_reg : date0_reg;
        tod_sel  = (date1_reg != 16'd0) ? tod1_reg : tod0_reg;
    end

    assign ent_valid = take && run && pos == 5'd31;
    always_comb
    begin
        ent.entry_index  = num;
        ent.status       = status_reg;
        ent.name_bad     = bad_reg;
        ent.first_sector = first_reg;
        ent.sector_total = total_reg;
        ent.date         = date_sel;
        ent.tod          = tod_sel;
        ent.pad          = pad_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            num_reg <= '0;
            run_reg <= 1'b0;
        end
        else
        begin
            if (fb.walk_end)
                run_reg <= 1'b0;
            if (take)
            begin
                run_reg <= run;
                if (run)
                begin
                    pos_reg <= pos + 5'd1;
                    num_reg <= (pos == 5'd31) ? num + 18'd1 : num;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && run)
        begin
            ended_reg <= ended;
            bad_reg <= bad;
            nonempty_reg <= nonempty;
            if (new_library)
            begin
                first_reg <= '0; total_reg <= '0; date0_reg <= '0; date1_reg <= '0;
                tod0_reg <= '0; tod1_reg <= '0; pad_reg <= '0;
            end
            unique case (pos)
                5'd0:  status_reg <= data_byte;
                5'd12: first_reg[7:0] <= data_byte;
                5'd13: first_reg[15:8] <= data_byte;
                5'd14: total_reg[7:0] <= data_byte;
                5'd15: total_reg[15:8] <= data_byte;
                5'd18: date0_reg[7:0] <= data_byte;
                5'd19: date0_reg[15:8] <= data_byte;
                5'd20: date1_reg[7:0] <= data_byte;
                5'd21: date1_reg[15:8] <= data_byte;
                5'd22: tod0_reg[7:0] <= data_byte;
                5'd23: tod0_reg[15:8] <= data_byte;
                5'd24: tod1_reg[7:0] <= data_byte;
                5'd25: tod1_reg[15:8] <= data_byte;
                5'd26: pad_reg <= data_byte;
                default: ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_ent_last: assert property (@(posedge clk) disable iff (!rst_n)
        ent_valid |-> ent_ready) else $error("entry pushed into full queue");
    a_pos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        ent_valid |=> pos_reg == 5'd0) else $error("byte position did not wrap");
    a_run_stop: assert property (@(posedge clk) disable iff (!rst_n)
        fb.walk_end && !(in_valid && in_ready && new_library) |=> !run_reg)
        else $error("walk kept running after end");
`endif
endmodule

[hdl/cpm_lbr_back.sv]
// Back end: classifies entries, keeps the walk totals and builds results.
`timescale 1ns / 1ps
module cpm_lbr_back #(
    parameter int SECTOR_BYTES = cpm_lbr_pkg::SECTOR_BYTES_DEF,
    parameter int MEMBER_LIMIT = cpm_lbr_pkg::MEMBER_LIMIT_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    ent_valid,
    input  cpm_lbr_pkg::entry_t     ent,
    input  logic                    new_walk,
    input  logic [31:0]             library_bytes,
    output cpm_lbr_pkg::walk_fb_t   fb,
    output logic                    res_valid,
    input  logic                    res_ready,
    output logic                    queue_ready,
    output cpm_lbr_pkg::result_t    res
);
    localparam int SH = $clog2(SECTOR_BYTES);
    // Stage 1 register (one item queue) and stage 2 output register.
    logic                  s1_valid_reg;
    cpm_lbr_pkg::entry_t   s1_reg;
    logic [15:0]           dirs_reg;
    logic                  past_end_reg;
    logic [16:0]           active_reg;
    logic [15:0]           trunc_reg;
    logic                  seen_reg;
    logic                  end_reg;
    logic                  out_valid_reg;
    cpm_lbr_pkg::result_t  out_reg;
    logic [16:0]           days_reg;
    logic [16:0]           tod_sec_reg;
    logic                  s2_adv, s1_adv;

    logic [2:0]  kind;
    logic        fail, done, pres, hts;
    logic [15:0] cnt, start;
    logic [22:0] mbytes;
    logic [33:0] off, lib34;
    logic [7:0]  pad;
    logic [15:0] dirs_n;
    logic        past_n, seen_n;
    logic [16:0] act_n;
    logic [15:0] tr_n;
    logic [17:0] last;
    logic [4:0]  hh;
    logic [5:0]  mm;
    logic [4:0]  hv;

    assign s2_adv = !out_valid_reg || res_ready;
    assign s1_adv = s1_valid_reg && s2_adv;
    assign queue_ready = !s1_valid_reg || s2_adv;

    always_comb
    begin
        kind = cpm_lbr_pkg::KIND_BAD;
        fail = 1'b0;
        cnt = '0; start = '0; mbytes = '0; pres = 1'b0; hts = 1'b0;
        dirs_n = dirs_reg; past_n = past_end_reg; seen_n = seen_reg;
        act_n = active_reg; tr_n = trunc_reg;
        off = {18'd0, s1_reg.first_sector} << SH;
        lib34 = {2'd0, library_bytes};
        pad = (s1_reg.pad >= 8'(SECTOR_BYTES) || s1_reg.sector_total == 16'd0)
            ? 8'd0 : s1_reg.pad;
        if (s1_reg.entry_index == 18'd0)
        begin
            if (s1_reg.status == cpm_lbr_pkg::ST_ACTIVE && !s1_reg.name_bad &&
                s1_reg.first_sector == 16'd0 && s1_reg.sector_total != 16'd0 &&
                lib34 >= 34'(SECTOR_BYTES) &&
                (({18'd0, s1_reg.sector_total}) << SH) <= lib34)
            begin
                kind = cpm_lbr_pkg::KIND_HEADER;
                dirs_n = s1_reg.sector_total;
                cnt = s1_reg.sector_total;
            end
            else
                fail = 1'b1;
        end
        else if (past_end_reg)
        begin
            if (s1_reg.status == cpm_lbr_pkg::ST_UNUSED) kind = cpm_lbr_pkg::KIND_UNUSED;
            else if (s1_reg.status == cpm_lbr_pkg::ST_DELETED)
                kind = cpm_lbr_pkg::KIND_DELETED;
            else fail = 1'b1;
        end
        else if (s1_reg.status == cpm_lbr_pkg::ST_UNUSED)
        begin
            kind = cpm_lbr_pkg::KIND_UNUSED;
            past_n = 1'b1;
        end
        else if (s1_reg.status == cpm_lbr_pkg::ST_DELETED)
            kind = cpm_lbr_pkg::KIND_DELETED;
        else if (s1_reg.status != cpm_lbr_pkg::ST_ACTIVE || s1_reg.name_bad)
            fail = 1'b1;
        else if (s1_reg.sector_total != 16'd0 && s1_reg.first_sector < dirs_reg)
            fail = 1'b1;
        else
        begin
            kind = cpm_lbr_pkg::KIND_ACTIVE;
            start = s1_reg.first_sector;
            cnt = s1_reg.sector_total;
            mbytes = 23'((({7'd0, s1_reg.sector_total}) << SH) - {15'd0, pad});
            pres = s1_reg.sector_total == 16'd0 ||
                   (off <= lib34 && {11'd0, mbytes} <= lib34 - off);
            hts = s1_reg.date != 16'd0;
            act_n = active_reg + 17'd1;
            if (act_n > 17'(MEMBER_LIMIT))
                fail = 1'b1;
            else if (pres)
            begin
                if (s1_reg.sector_total != 16'd0) seen_n = 1'b1;
            end
            else
                tr_n = trunc_reg + 16'd1;
        end
        if (fail && kind != cpm_lbr_pkg::KIND_ACTIVE)
        begin
            kind = cpm_lbr_pkg::KIND_BAD;
            cnt = '0;
        end
        last = 18'(({2'd0, dirs_n} << (SH - 5)) - 18'd1);
        done = fail || (dirs_n != 16'd0 && s1_reg.entry_index >= last);
        hh = s1_reg.tod[15:11];
        mm = s1_reg.tod[10:5];
        hv = s1_reg.tod[4:0];
    end

    assign fb.walk_end = end_reg;
    assign fb.dir_sectors = dirs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            dirs_reg <= '0; past_end_reg <= 1'b0; active_reg <= '0;
            trunc_reg <= '0; seen_reg <= 1'b0; end_reg <= 1'b0;
        end
        else
        begin
            end_reg <= 1'b0;
            if (s2_adv)
                out_valid_reg <= s1_valid_reg;
            if (queue_ready)
                s1_valid_reg <= ent_valid;
            if (new_walk)
            begin
                dirs_reg <= '0; past_end_reg <= 1'b0; active_reg <= '0;
                trunc_reg <= '0; seen_reg <= 1'b0;
            end
            else if (s1_adv)
            begin
                dirs_reg <= dirs_n; past_end_reg <= past_n; active_reg <= act_n;
                trunc_reg <= tr_n; seen_reg <= seen_n; end_reg <= done;
            end
        end
    end

    // The timestamp is finished in the output stage: the multiply by 86400 follows the output register.
    always_ff @(posedge clk)
    begin
        if (queue_ready && ent_valid)
            s1_reg <= ent;
        if (s1_adv)
        begin
            days_reg <= 17'd2921 + {1'b0, s1_reg.date};
            tod_sec_reg <= (hh < 5'd24 && mm < 6'd60 && hv < 5'd30) ?
                17'(hh * 17'd3600 + mm * 17'd60 + {hv, 1'b0}) : 17'd0;
            out_reg.entry_index <= s1_reg.entry_index;
            out_reg.entry_kind <= kind;
            out_reg.start_sector <= start;
            out_reg.sector_count <= cnt;
            out_reg.member_bytes <= mbytes;
            out_reg.present <= pres;
            out_reg.has_timestamp <= hts;
            out_reg.timestamp_seconds <= '0;
            out_reg.library_done <= done;
            out_reg.library_valid <= done && !fail && seen_n;
            out_reg.active_count <= act_n[16] ? 16'hFFFF : act_n[15:0];
            out_reg.truncated_count <= tr_n;
        end
    end

    always_comb
    begin
        res = out_reg;
        res.timestamp_seconds = out_reg.has_timestamp ?
            33'(days_reg * 34'd86400 + {17'd0, tod_sec_reg}) : 33'd0;
    end
    assign res_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid) else $error("result dropped");
    a_valid_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.library_valid |-> res.library_done)
        else $error("verdict without done");
    a_end_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        end_reg |-> $past(s1_adv)) else $error("walk end without entry");
`endif
endmodule
